// ----- rtl/ipv4cp_pkg.sv -----
package ipv4cp_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PlenW   = 6;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned AccW    = 9;
  localparam int unsigned ProdW   = 13;
  localparam int unsigned OutDataW = 48;

  localparam logic [PhaseW-1:0] PH_OCT3   = 3'd3;
  localparam logic [PhaseW-1:0] PH_PREFIX = 3'd4;
  localparam logic [PhaseW-1:0] PH_WAIT   = 3'd5;

  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID    = 3'd1;
  localparam logic [StatusW-1:0] ST_OCTET_OVF  = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_PREFIX  = 3'd3;
  localparam logic [StatusW-1:0] ST_PREFIX_OVF = 3'd4;

  localparam logic [ChW-1:0] CH_END   = 8'h00;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ChW-1:0] CH_SLASH = 8'h2F;

  localparam logic [ChW-1:0]   DIGIT_LIMIT = 8'd10;
  localparam logic [ProdW-1:0] TEN         = 13'd10;
  localparam logic [ProdW-1:0] OCTET_MAX   = 13'd255;
  localparam logic [ProdW-1:0] PREFIX_MAX  = 13'd32;
  localparam logic [ProdW-1:0] ACC_SAT     = 13'd511;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AccW-1:0]   accum;
    logic              seen;
    logic [AddrW-1:0]  addr;
  } parse_state_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   address;
    logic [PlenW-1:0]   prefix_len;
  } parse_result_t;

endpackage

// ----- rtl/ipv4_cidr_text_parser.sv -----
// Character-serial parser for "a.b.c.d/p" address text.
// The slave stream carries one character per word in s_axis_tdata; a zero
// character ends the string. The master stream carries at most one result per
// string, given as soon as the outcome is decided: status, address and prefix.
// Characters after a result are dropped up to and including the end byte,
// after which a fresh string begins.
// A character is captured in an input register at the accepting edge and
// processed against the parser state once the output register is free or
// being emptied; any result is then written to the output register and
// shown on m_axis_tvalid from there.
// Throughput is one character per cycle while the receiver keeps up; the
// limit is the single state update per character.
// When the receiver stalls with a result held, the captured character waits
// in the input register and s_axis_tready falls until the result is taken.
// Reset clears the parser state and both registers' valid flags, so the
// block starts on a fresh string with no result pending.
module ipv4_cidr_text_parser import ipv4cp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ChW-1:0]      s_axis_tdata,  // [7:0] ch
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // [2:0] status, [34:3] address,
                                             // [40:35] prefix_len, rest zero
);

  logic           in_vld_q;
  logic [ChW-1:0] in_ch_q;
  logic           out_vld_q, out_vld_d;
  parse_result_t  out_res_q;
  parse_state_t   st_q, st_d;
  logic           emit;
  parse_result_t  res;
  logic           advance;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  ipv4cp_step u_step (
    .ch_i   (in_ch_q),
    .cur_i  (st_q),
    .nxt_o  (st_d),
    .emit_o (emit),
    .res_o  (res)
  );

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (in_vld_q && advance) begin
      out_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      out_vld_q <= out_vld_d;
      if (in_vld_q && advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q <= s_axis_tdata;
    end
    if (in_vld_q && advance && emit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_res_q.prefix_len, out_res_q.address,
                          out_res_q.status};

endmodule

// ----- rtl/ipv4cp_step.sv -----
module ipv4cp_step import ipv4cp_pkg::*; (
  input  logic [ChW-1:0] ch_i,
  input  parse_state_t   cur_i,
  output parse_state_t   nxt_o,
  output logic           emit_o,
  output parse_result_t  res_o
);

  logic [ChW-1:0]   dv;
  logic             is_digit;
  logic [ProdW-1:0] v;
  logic [AccW-1:0]  v_sat;
  logic [AddrW-1:0] addr_sh;
  parse_state_t     upd;

  assign dv       = ch_i - CH_ZERO;
  assign is_digit = dv < DIGIT_LIMIT;
  assign v        = ({4'b0, cur_i.accum} * TEN) + {5'b0, dv};
  assign v_sat    = (v > ACC_SAT) ? ACC_SAT[AccW-1:0] : v[AccW-1:0];
  assign addr_sh  = {cur_i.addr[AddrW-9:0], cur_i.accum[7:0]};

  always_comb begin
    upd    = cur_i;
    emit_o = 1'b0;
    res_o  = '0;
    if (cur_i.phase <= PH_OCT3) begin
      if (is_digit) begin
        upd.seen  = 1'b1;
        upd.accum = v_sat;
        if (v > OCTET_MAX) begin
          emit_o       = 1'b1;
          res_o.status = ST_OCTET_OVF;
        end
      end else if (!cur_i.seen) begin
        emit_o       = 1'b1;
        res_o.status = ST_INVALID;
      end else if (cur_i.phase < PH_OCT3) begin
        if (ch_i != CH_DOT) begin
          emit_o       = 1'b1;
          res_o.status = ST_INVALID;
        end else begin
          upd.addr  = addr_sh;
          upd.accum = '0;
          upd.seen  = 1'b0;
          upd.phase = cur_i.phase + 3'd1;
        end
      end else begin
        upd.addr  = addr_sh;
        upd.accum = '0;
        upd.seen  = 1'b0;
        if (ch_i != CH_SLASH) begin
          emit_o        = 1'b1;
          res_o.status  = ST_NO_PREFIX;
          res_o.address = addr_sh;
        end else begin
          upd.phase = PH_PREFIX;
        end
      end
    end else if (cur_i.phase == PH_PREFIX) begin
      if (is_digit) begin
        upd.seen  = 1'b1;
        upd.accum = v_sat;
        if (v > PREFIX_MAX) begin
          emit_o        = 1'b1;
          res_o.status  = ST_PREFIX_OVF;
          res_o.address = cur_i.addr;
        end
      end else if (!cur_i.seen) begin
        emit_o = 1'b1;
        if (ch_i == CH_END) begin
          res_o.status  = ST_NO_PREFIX;
          res_o.address = cur_i.addr;
        end else begin
          res_o.status = ST_INVALID;
        end
      end else begin
        emit_o           = 1'b1;
        res_o.status     = ST_OK;
        res_o.address    = cur_i.addr;
        res_o.prefix_len = cur_i.accum[PlenW-1:0];
      end
    end

    nxt_o = upd;
    if (emit_o) begin
      if (ch_i == CH_END) begin
        nxt_o = '0;
      end else begin
        nxt_o.phase = PH_WAIT;
      end
    end else if (cur_i.phase > PH_PREFIX && ch_i == CH_END) begin
      nxt_o = '0;
    end
  end

endmodule

// ----- rtl/ipv4cp_checker.sv -----
module ipv4cp_checker import ipv4cp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   address;
  logic [PlenW-1:0]   plen;

  assign status  = m_axis_tdata[2:0];
  assign address = m_axis_tdata[34:3];
  assign plen    = m_axis_tdata[40:35];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status <= ST_PREFIX_OVF)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_INVALID || status == ST_OCTET_OVF)
      |-> address == '0 && plen == '0)
    else $error("failed parse carries address or prefix");

  a_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == ST_OK) ? (plen <= 6'd32) : (plen == '0))
    else $error("prefix length inconsistent with status");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s_axis_tvalid && s_axis_tready) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result word without a preceding character");

endmodule

bind ipv4_cidr_text_parser ipv4cp_checker u_ipv4cp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
